FILE: hw/rtl/dnymd_pkg.sv
`default_nettype none

package dnymd_pkg;

    // width of the day count taken from the input
    localparam int unsigned DAY_BITS = 22;

    // calendar block lengths in days
    localparam int unsigned BASE_YEAR     = 1601;
    localparam int unsigned YEAR_DAYS     = 365;
    localparam int unsigned QUAD_DAYS     = YEAR_DAYS * 4 + 1;
    localparam int unsigned CENT_DAYS     = YEAR_DAYS * 100 + 24;
    localparam int unsigned QUADCENT_DAYS = CENT_DAYS * 4 + 1;

    // most 400-year blocks a count can hold, and 4-year blocks in a century
    localparam int unsigned QC_MAX  = ((1 << DAY_BITS) - 1) / QUADCENT_DAYS;
    localparam int unsigned QC_BITS = $clog2(QC_MAX + 2);
    localparam int unsigned QUAD_MAX  = CENT_DAYS / QUAD_DAYS;
    localparam int unsigned QUAD_BITS = $clog2(QUAD_MAX + 1);

    // remainder widths after each split
    localparam int unsigned REM_QC_BITS   = $clog2(QUADCENT_DAYS);
    localparam int unsigned REM_CENT_BITS = $clog2(CENT_DAYS + 1);
    localparam int unsigned REM_QUAD_BITS = $clog2(QUAD_DAYS);
    localparam int unsigned DOY_BITS      = $clog2(YEAR_DAYS + 1);

    // internal year width and the width of the year port
    localparam int unsigned YEAR_CALC_BITS = $clog2(BASE_YEAR + 400 * (QC_MAX + 1));
    localparam int unsigned YEAR_BITS      = 14;
    localparam int unsigned MONTH_BITS     = 4;
    localparam int unsigned DOM_BITS       = 5;

    // months in a year
    localparam int unsigned MONTHS = 12;

    typedef struct packed {
        logic [YEAR_CALC_BITS-1:0] year;
        logic [MONTH_BITS-1:0]     month;
        logic [DOM_BITS-1:0]       day_of_month;
    } date_t;

    // zero based day of year on which month idx (0 = January) starts
    function automatic logic [DOY_BITS-1:0] month_start(
        input logic [MONTH_BITS-1:0] idx,
        input logic                  leap
    );
        logic [DOY_BITS-1:0] start;
        logic [DOY_BITS-1:0] extra;
        extra = leap ? DOY_BITS'(1) : DOY_BITS'(0);
        unique case (idx)
            4'd0:    start = DOY_BITS'(0);
            4'd1:    start = DOY_BITS'(31);
            4'd2:    start = DOY_BITS'(59) + extra;
            4'd3:    start = DOY_BITS'(90) + extra;
            4'd4:    start = DOY_BITS'(120) + extra;
            4'd5:    start = DOY_BITS'(151) + extra;
            4'd6:    start = DOY_BITS'(181) + extra;
            4'd7:    start = DOY_BITS'(212) + extra;
            4'd8:    start = DOY_BITS'(243) + extra;
            4'd9:    start = DOY_BITS'(273) + extra;
            4'd10:   start = DOY_BITS'(304) + extra;
            4'd11:   start = DOY_BITS'(334) + extra;
            default: start = DOY_BITS'(0);
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dnymd_convert.sv
`default_nettype none

module dnymd_convert (
    input  wire logic [dnymd_pkg::DAY_BITS-1:0] day,
    output dnymd_pkg::date_t                    date
);
    import dnymd_pkg::*;

    logic [QC_BITS-1:0]       qc;
    logic [REM_QC_BITS-1:0]   rem_qc;
    logic [1:0]               cent;
    logic [REM_CENT_BITS-1:0] rem_cent;
    logic [QUAD_BITS-1:0]     quad;
    logic [REM_QUAD_BITS-1:0] rem_quad;
    logic [1:0]               yr;
    logic [DOY_BITS-1:0]      doy;
    logic                     leap;
    logic [MONTH_BITS-1:0]    mon_idx;
    logic [DOY_BITS-1:0]      mon_first;

    // 400-year blocks: compare against every multiple, keep the highest hit
    always_comb
    begin
        logic [31:0] d_wide;
        logic [31:0] off;
        d_wide = 32'(day);
        off    = 32'd0;
        qc     = '0;
        for (int unsigned i = 1; i <= QC_MAX; i++)
        begin
            if (d_wide >= i * QUADCENT_DAYS)
            begin
                qc  = QC_BITS'(i);
                off = i * QUADCENT_DAYS;
            end
        end
        rem_qc = REM_QC_BITS'(d_wide - off);
    end

    // 100-year blocks, capped at three
    always_comb
    begin
        logic [31:0] r_wide;
        r_wide = 32'(rem_qc);
        priority if (r_wide >= 3 * CENT_DAYS)
        begin
            cent     = 2'd3;
            rem_cent = REM_CENT_BITS'(r_wide - 3 * CENT_DAYS);
        end
        else if (r_wide >= 2 * CENT_DAYS)
        begin
            cent     = 2'd2;
            rem_cent = REM_CENT_BITS'(r_wide - 2 * CENT_DAYS);
        end
        else if (r_wide >= CENT_DAYS)
        begin
            cent     = 2'd1;
            rem_cent = REM_CENT_BITS'(r_wide - CENT_DAYS);
        end
        else
        begin
            cent     = 2'd0;
            rem_cent = REM_CENT_BITS'(r_wide);
        end
    end

    // 4-year blocks inside the century
    always_comb
    begin
        logic [31:0] r_wide;
        logic [31:0] off;
        r_wide = 32'(rem_cent);
        off    = 32'd0;
        quad   = '0;
        for (int unsigned i = 1; i <= QUAD_MAX; i++)
        begin
            if (r_wide >= i * QUAD_DAYS)
            begin
                quad = QUAD_BITS'(i);
                off  = i * QUAD_DAYS;
            end
        end
        rem_quad = REM_QUAD_BITS'(r_wide - off);
    end

    // single years, capped at three so 31 december of a leap year stays put
    always_comb
    begin
        logic [31:0] r_wide;
        r_wide = 32'(rem_quad);
        priority if (r_wide >= 3 * YEAR_DAYS)
        begin
            yr  = 2'd3;
            doy = DOY_BITS'(r_wide - 3 * YEAR_DAYS);
        end
        else if (r_wide >= 2 * YEAR_DAYS)
        begin
            yr  = 2'd2;
            doy = DOY_BITS'(r_wide - 2 * YEAR_DAYS);
        end
        else if (r_wide >= YEAR_DAYS)
        begin
            yr  = 2'd1;
            doy = DOY_BITS'(r_wide - YEAR_DAYS);
        end
        else
        begin
            yr  = 2'd0;
            doy = DOY_BITS'(r_wide);
        end
    end

    // leap from block position: last year of a quad, except the century's
    // last quad unless it is the last century of the 400-year block
    assign leap = (yr == 2'd3) && ((quad != QUAD_BITS'(QUAD_MAX)) || (cent == 2'd3));

    // month search over the month start table
    always_comb
    begin
        mon_idx = '0;
        for (int unsigned i = 1; i < MONTHS; i++)
        begin
            if (doy >= month_start(MONTH_BITS'(i), leap))
            begin
                mon_idx = MONTH_BITS'(i);
            end
        end
        mon_first = month_start(mon_idx, leap);
    end

    // assemble the date
    assign date.year = YEAR_CALC_BITS'(BASE_YEAR)
                     + YEAR_CALC_BITS'(qc) * YEAR_CALC_BITS'(400)
                     + YEAR_CALC_BITS'(cent) * YEAR_CALC_BITS'(100)
                     + YEAR_CALC_BITS'(quad) * YEAR_CALC_BITS'(4)
                     + YEAR_CALC_BITS'(yr);
    assign date.month        = mon_idx + MONTH_BITS'(1);
    assign date.day_of_month = DOM_BITS'(doy - mon_first + DOY_BITS'(1));

endmodule

`default_nettype wire

FILE: hw/rtl/day_number_to_ymd.sv
// day count (0 = 1 january 1601) to gregorian year, month and day of month
// day_reg captures the accepted count, then the result registers and done_reg capture the date
// throughput: one transfer per cycle; busy stays low, a new count may start
// every cycle over the single register-to-register conversion path
// done pulses for one cycle per result; the receiver cannot stall it
// reset: rst_n asynchronous active low clears the valid flags, no result pending
`default_nettype none

module day_number_to_ymd (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [dnymd_pkg::DAY_BITS-1:0]   day_number,
    output logic                                  done,
    output logic [dnymd_pkg::YEAR_BITS-1:0]       year,
    output logic [dnymd_pkg::MONTH_BITS-1:0]      month,
    output logic [dnymd_pkg::DOM_BITS-1:0]        day_of_month
);
    import dnymd_pkg::*;

    logic                  accept;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [DAY_BITS-1:0]   day_reg;
    logic                  done_reg;
    logic                  done_next;
    logic [YEAR_BITS-1:0]  year_reg;
    logic [MONTH_BITS-1:0] month_reg;
    logic [DOM_BITS-1:0]   dom_reg;
    date_t                 date;

    // never stalls the sender
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_valid_next = accept;
    assign done_next     = in_valid_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            done_reg     <= done_next;
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_reg <= day_number;
        end
    end

    dnymd_convert u_convert (
        .day  (day_reg),
        .date (date)
    );

    // result capture
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            year_reg  <= date.year[YEAR_BITS-1:0];
            month_reg <= date.month;
            dom_reg   <= date.day_of_month;
        end
    end

    assign done         = done_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;

    // every accepted count gives a result once it has passed the input and result registers
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted transfer produced no result");

    // no result without an accepted count
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without accepted transfer");

    // month within range
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month >= 4'd1) && (month <= 4'd12))
        else $error("month out of range");

    // day within the month length
    a_dom_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (day_of_month >= 5'd1)
              && ((month != 4'd2) || (day_of_month <= 5'd29))
              && (((month != 4'd4) && (month != 4'd6) && (month != 4'd9)
                   && (month != 4'd11)) || (day_of_month <= 5'd30)))
        else $error("day of month out of range");

endmodule

`default_nettype wire
